@@ hw/rtl/trwp_pkg.sv @@
package trwp_pkg;

    localparam int MAX_RECORDS = 16384;
    localparam int MAX_BURST   = 64;

    localparam int IDX_W   = 14;
    localparam int LEN_W   = 15;
    localparam int BYTE_W  = 8;
    localparam int DELAY_W = 16;
    localparam int REC_W   = 2 * BYTE_W + DELAY_W;
    localparam int BURST_W = $clog2(MAX_BURST + 1);

    localparam logic [LEN_W-1:0]   LEN_MIN   = LEN_W'(1);
    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_RECORDS);
    localparam logic [DELAY_W-1:0] CD_RESET  = DELAY_W'(1);
    localparam logic [BURST_W-1:0] BURST_CAP = BURST_W'(MAX_BURST);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic tick_start;
        logic rd_issue;
        logic rec_take;
    } cmd_t;

    typedef struct packed {
        logic burst_go;
        logic last;
    } stat_t;

endpackage

@@ hw/rtl/trwp_in_if.sv @@
interface trwp_in_if
    import trwp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [IDX_W-1:0]   record_index;
    logic [BYTE_W-1:0]  load_reg_addr;
    logic [BYTE_W-1:0]  load_reg_value;
    logic [DELAY_W-1:0] load_delay;

    modport source (
        output valid, func, record_index, load_reg_addr, load_reg_value, load_delay,
        input  ready
    );
    modport sink (
        input  valid, func, record_index, load_reg_addr, load_reg_value, load_delay,
        output ready
    );
endinterface

@@ hw/rtl/trwp_out_if.sv @@
interface trwp_out_if
    import trwp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] reg_value;
    logic              last_in_burst;

    modport source (
        output valid, reg_addr, reg_value, last_in_burst,
        input  ready
    );
    modport sink (
        input  valid, reg_addr, reg_value, last_in_burst,
        output ready
    );
endinterface

@@ hw/rtl/trwp_cfg_if.sv @@
interface trwp_cfg_if
    import trwp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

@@ hw/rtl/trwp_ctrl.sv @@
module trwp_ctrl
    import trwp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  logic  item_func,
    output logic  item_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && item_func == FUNC_TICK)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.burst_go ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_ready)
                begin
                    state_next = stat.last ? ST_IDLE : ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready     = 1'b0;
        result_valid   = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready     = 1'b1;
                cmd.load_wr    = item_valid && item_func == FUNC_LOAD;
                cmd.tick_start = item_valid && item_func == FUNC_TICK;
            end
            ST_CHECK:
            begin
                cmd.rd_issue = stat.burst_go;
            end
            ST_READ:
            begin
                cmd.rec_take = 1'b1;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/trwp_datapath.sv @@
module trwp_datapath
    import trwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic               cfg_wr,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic [IDX_W-1:0]   record_index,
    input  logic [BYTE_W-1:0]  load_reg_addr,
    input  logic [BYTE_W-1:0]  load_reg_value,
    input  logic [DELAY_W-1:0] load_delay,
    output logic [BYTE_W-1:0]  reg_addr,
    output logic [BYTE_W-1:0]  reg_value,
    output logic               last_in_burst
);

    logic [REC_W-1:0]   mem [MAX_RECORDS];
    logic [REC_W-1:0]   rd_data_reg;

    logic [LEN_W-1:0]   song_records_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [DELAY_W-1:0] cd_reg;
    logic [DELAY_W-1:0] cd_next;
    logic [BURST_W-1:0] count_reg;
    logic [BURST_W-1:0] count_next;

    logic [BYTE_W-1:0]  addr_reg;
    logic [BYTE_W-1:0]  value_reg;
    logic               last_reg;

    logic [LEN_W-1:0]   song_len;
    logic [LEN_W-1:0]   pos_inc;
    logic [DELAY_W-1:0] rd_delay;
    logic               rec_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            mem[record_index] <= {load_delay, load_reg_value, load_reg_addr};
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[pos_reg];
        end
    end

    always_comb
    begin
        if (song_records_reg == '0)
        begin
            song_len = LEN_MIN;
        end
        else if (song_records_reg > LEN_MAX)
        begin
            song_len = LEN_MAX;
        end
        else
        begin
            song_len = song_records_reg;
        end
    end

    assign pos_inc  = {1'b0, pos_reg} + LEN_W'(1);
    assign rd_delay = rd_data_reg[REC_W-1 -: DELAY_W];
    assign rec_last = (rd_delay != '0) || (count_reg == BURST_CAP - BURST_W'(1));

    always_comb
    begin
        pos_next   = pos_reg;
        cd_next    = cd_reg;
        count_next = count_reg;
        if (cmd.tick_start)
        begin
            count_next = '0;
            if (cd_reg != '0)
            begin
                cd_next = cd_reg - DELAY_W'(1);
            end
        end
        if (cmd.rec_take)
        begin
            cd_next    = rd_delay;
            count_next = count_reg + BURST_W'(1);
            pos_next   = (pos_inc >= song_len) ? '0 : pos_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_records_reg <= LEN_MIN;
            pos_reg          <= '0;
            cd_reg           <= CD_RESET;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                song_records_reg <= cfg_data;
            end
            pos_reg   <= pos_next;
            cd_reg    <= cd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rec_take)
        begin
            addr_reg  <= rd_data_reg[BYTE_W-1:0];
            value_reg <= rd_data_reg[2*BYTE_W-1 -: BYTE_W];
            last_reg  <= rec_last;
        end
    end

    assign stat.burst_go = (cd_reg == '0) && (count_reg < BURST_CAP);
    assign stat.last     = last_reg;

    assign reg_addr      = addr_reg;
    assign reg_value     = value_reg;
    assign last_in_burst = last_reg;

endmodule

@@ hw/rtl/timed_register_write_player.sv @@
// Timed register write player.
// item channel: one beat per tick (func = 0) or per record load (func = 1).
//   A load writes the record into the 16384-entry store and produces no
//   result; the block is ready again on the next cycle.
// result channel: one beat per sound chip register write; last_in_burst
//   marks the final write caused by a tick.
// cfg channel: always ready; each beat sets the song length in records.
// Sequence: a tick with no write due returns straight to idle. Each write of a
//   burst passes through the position check with store read, the output
//   register load and the emit step, which waits while the receiver holds
//   ready low. Writes are fetched one at a time through the single read port.
//   A burst stops after 64 writes and resumes on the next tick.
// Items are taken only while no tick is being processed; a stalled result
//   holds its beat and the block waits without losing state.
// Reset: play position 0, countdown 1, song length 1. Store contents are
//   undefined until loaded; no clearing pass is run.
module timed_register_write_player
    import trwp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    trwp_in_if.sink    item,
    trwp_out_if.source result,
    trwp_cfg_if.sink   cfg
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    trwp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_func    (item.func),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    trwp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr         (cfg.valid),
        .cfg_data       (cfg.data),
        .record_index   (item.record_index),
        .load_reg_addr  (item.load_reg_addr),
        .load_reg_value (item.load_reg_value),
        .load_delay     (item.load_delay),
        .reg_addr       (result.reg_addr),
        .reg_value      (result.reg_value),
        .last_in_burst  (result.last_in_burst)
    );

endmodule
